/* design/rdlm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdlm_pkg
// Shared constants for the RMS dBFS level meter.
// ----------------------------------------------------------------------------
package rdlm_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SUM_W_DEF       = $clog2(MAX_SAMPLES_DEF) + 31;
    localparam int CNT_W_DEF       = $clog2(MAX_SAMPLES_DEF + 1);

    localparam int SAMPLE_W   = 16;
    localparam int DB_W       = 8;
    localparam int METER_W    = 6;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam int MANT_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int LOG_OFFSET_Q16 = 30 * 65536;
    localparam logic [17:0] TEN_LOG10_2_Q16 = 18'd197283;

    localparam logic signed [DB_W-1:0] DB_SILENCE = -8'sd96;
    localparam logic signed [DB_W-1:0] DB_MIN     = -8'sd128;
    localparam int DB_CLAMP = 128;
    localparam int DB_OFFSET = 60;

    // floor(n / 3) = (n * 171) >> 9 for n up to 120
    localparam logic [7:0] DIV3_MUL   = 8'd171;
    localparam int         DIV3_SHIFT = 9;

endpackage

/* design/rms_dbfs_level_meter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_dbfs_level_meter
// Chunk level meter: sum of squares of 16-bit PCM, dBFS and 0..40 VU level.
// ----------------------------------------------------------------------------
// Input stream: s_tdata[15:0] carries one signed PCM sample, s_tlast marks
// the final sample of a chunk. A chunk also closes when its count reaches
// MAX_SAMPLES. Samples are taken one per cycle; the intake never stalls
// unless two closed chunks already wait in the queue.
// Output stream: one transfer per chunk, m_tdata[7:0] = dBFS level (signed),
// m_tdata[13:8] = meter level 0..40.
// From the closing sample to m_tvalid, a silent chunk passes the queue and
// then only the IDLE and FINISH states; otherwise the chunk takes two passes
// of the shared log2 unit (bit-serial normalize over SUM_W+1 bits, then 16
// squaring steps) followed by the MUL and SAT states, skipped at or above full scale, and FINISH.
// The level stage takes no new chunk until the current one leaves FINISH, so the log2 unit sets the chunk rate.
// Reset clears the accumulators, the queue and the output valid.
// A stalled receiver holds the result in the output register; the level
// stage then waits, and the queue fills before intake stalls.
// ----------------------------------------------------------------------------
module rms_dbfs_level_meter #(
    parameter int MAX_SAMPLES = rdlm_pkg::MAX_SAMPLES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rdlm_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] sample
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rdlm_pkg::M_TDATA_W-1:0] m_tdata    // [7:0] db_level, [13:8] meter_level
);

    localparam int SUM_W = $clog2(MAX_SAMPLES) + 31;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    logic             push_valid;
    logic             push_ready;
    logic [SUM_W-1:0] push_sum;
    logic [CNT_W-1:0] push_cnt;
    logic             pop_valid;
    logic             pop_ready;
    logic [SUM_W-1:0] pop_sum;
    logic [CNT_W-1:0] pop_cnt;

    rdlm_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_sum   (push_sum),
        .push_cnt   (push_cnt)
    );

    rdlm_queue #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_sum   (push_sum),
        .push_cnt   (push_cnt),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_sum    (pop_sum),
        .pop_cnt    (pop_cnt)
    );

    rdlm_back #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .q_sum    (pop_sum),
        .q_cnt    (pop_cnt),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* design/rdlm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdlm_front
// Sample intake: squares each sample, accumulates the chunk sum and count,
// and pushes the closed chunk into the queue.
// ----------------------------------------------------------------------------
module rdlm_front #(
    parameter int MAX_SAMPLES = rdlm_pkg::MAX_SAMPLES_DEF,
    parameter int SUM_W       = rdlm_pkg::SUM_W_DEF,
    parameter int CNT_W       = rdlm_pkg::CNT_W_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rdlm_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] sample
    input  logic                           s_tlast,
    output logic                           push_valid,
    input  logic                           push_ready,
    output logic [SUM_W-1:0]               push_sum,
    output logic [CNT_W-1:0]               push_cnt
);

    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  cnt_next;
    logic signed [31:0] square;
    logic              accept;
    logic              close;

    assign square   = $signed(s_tdata[rdlm_pkg::SAMPLE_W-1:0])
                    * $signed(s_tdata[rdlm_pkg::SAMPLE_W-1:0]);
    assign sum_next = sum_reg + SUM_W'($unsigned(square));
    assign cnt_next = cnt_reg + CNT_W'(1);
    assign close    = s_tlast || (cnt_next >= CNT_W'(MAX_SAMPLES));

    assign s_tready   = push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = accept && close;
    assign push_sum   = sum_next;
    assign push_cnt   = cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (accept) begin
            if (close) begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end else begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

/* design/rdlm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdlm_queue
// Short queue of closed chunks between intake and level computation.
// ----------------------------------------------------------------------------
module rdlm_queue #(
    parameter int SUM_W = rdlm_pkg::SUM_W_DEF,
    parameter int CNT_W = rdlm_pkg::CNT_W_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [SUM_W-1:0] push_sum,
    input  logic [CNT_W-1:0] push_cnt,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [SUM_W-1:0] pop_sum,
    output logic [CNT_W-1:0] pop_cnt
);

    localparam int DEPTH = rdlm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [SUM_W-1:0]  sum_mem [DEPTH];
    logic [CNT_W-1:0]  cnt_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != FILL_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_sum    = sum_mem[rd_ptr_reg];
    assign pop_cnt    = cnt_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            sum_mem[wr_ptr_reg] <= push_sum;
            cnt_mem[wr_ptr_reg] <= push_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

endmodule

/* design/rdlm_log2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdlm_log2
// Iterative log2 in unsigned Q16: bit-serial normalize, then one squaring
// step per fraction bit.
// ----------------------------------------------------------------------------
module rdlm_log2 #(
    parameter int NORM_W = rdlm_pkg::SUM_W_DEF + 1
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       start,
    input  logic [NORM_W-1:0]                          x,
    output logic                                       done,
    output logic [$clog2(NORM_W)+rdlm_pkg::FRAC_W-1:0] result
);

    localparam int EW     = $clog2(NORM_W);
    localparam int MW     = rdlm_pkg::MANT_W;
    localparam int FW     = rdlm_pkg::FRAC_W;
    localparam int STEP_W = $clog2(FW);

    typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQR} lg_state_t;

    lg_state_t          state_reg;
    logic               done_reg;
    logic [NORM_W-1:0]  xn_reg;
    logic [EW-1:0]      e_reg;
    logic [MW-1:0]      m_reg;
    logic [FW-1:0]      frac_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [EW+FW-1:0]   result_reg;
    logic [2*MW-1:0]    sq;
    logic [MW:0]        sq_shift;
    logic               frac_bit;
    logic [MW-1:0]      m_next;
    logic [FW-1:0]      frac_next;

    assign sq        = m_reg * m_reg;
    assign sq_shift  = sq[2*MW-1:MW-1];
    assign frac_bit  = sq_shift[MW];
    assign m_next    = frac_bit ? sq_shift[MW:1] : sq_shift[MW-1:0];
    assign frac_next = {frac_reg[FW-2:0], frac_bit};

    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        xn_reg <= x;
                        e_reg  <= EW'(NORM_W - 1);
                        if (x == '0) begin
                            result_reg <= '0;
                            done_reg   <= 1'b1;
                        end else begin
                            state_reg <= L_NORM;
                        end
                    end
                end
                L_NORM: begin
                    if (xn_reg[NORM_W-1]) begin
                        m_reg     <= xn_reg[NORM_W-1 -: MW];
                        frac_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= L_SQR;
                    end else begin
                        xn_reg <= {xn_reg[NORM_W-2:0], 1'b0};
                        e_reg  <= e_reg - EW'(1);
                    end
                end
                L_SQR: begin
                    m_reg    <= m_next;
                    frac_reg <= frac_next;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(FW - 1)) begin
                        result_reg <= {e_reg, frac_next};
                        done_reg   <= 1'b1;
                        state_reg  <= L_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

/* design/rdlm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdlm_back
// Level computation: log2 of sum and count, scale to dB, saturate, derive
// the meter level, and hold the result in the output register.
// ----------------------------------------------------------------------------
module rdlm_back #(
    parameter int SUM_W = rdlm_pkg::SUM_W_DEF,
    parameter int CNT_W = rdlm_pkg::CNT_W_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  logic [SUM_W-1:0]               q_sum,
    input  logic [CNT_W-1:0]               q_cnt,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rdlm_pkg::M_TDATA_W-1:0] m_tdata  // [7:0] db_level, [13:8] meter_level
);

    localparam int NORM_W = SUM_W + 1;
    localparam int EW     = $clog2(NORM_W);
    localparam int LGW    = EW + rdlm_pkg::FRAC_W;
    localparam int LW     = LGW + 2;
    localparam int PW     = LW + 18;
    localparam int DBM_W  = PW - 32;
    localparam int DB_W   = rdlm_pkg::DB_W;
    localparam int MT_W   = rdlm_pkg::METER_W;

    typedef enum logic [2:0] {B_IDLE, B_LOG_SUM, B_LOG_CNT, B_MUL, B_SAT, B_FINISH} bk_state_t;

    bk_state_t               state_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [LGW-1:0]          lsum_reg;
    logic [LW-1:0]           mag_reg;
    logic [PW-1:0]           prod_reg;
    logic signed [DB_W-1:0]  db_reg;
    logic signed [DB_W-1:0]  out_db_reg;
    logic [MT_W-1:0]         out_meter_reg;
    logic                    m_tvalid_reg;

    logic                    lg_start;
    logic [NORM_W-1:0]       lg_x;
    logic                    lg_done;
    logic [LGW-1:0]          lg_result;
    logic signed [LW-1:0]    l_val;
    logic [DBM_W-1:0]        db_mag;
    logic signed [DB_W:0]    meter_t;
    logic [6:0]              meter_n;
    logic [14:0]             meter_p;
    logic [MT_W-1:0]         meter_next;
    logic                    out_free;

    assign q_ready  = (state_reg == B_IDLE);
    assign lg_start = ((state_reg == B_IDLE) && q_valid && (q_sum != '0))
                   || ((state_reg == B_LOG_SUM) && lg_done);
    assign lg_x     = (state_reg == B_IDLE) ? {1'b0, q_sum}
                                            : {{(NORM_W-CNT_W){1'b0}}, cnt_reg};

    rdlm_log2 #(
        .NORM_W (NORM_W)
    ) u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lg_start),
        .x       (lg_x),
        .done    (lg_done),
        .result  (lg_result)
    );

    assign l_val  = $signed({2'b00, lsum_reg}) - $signed({2'b00, lg_result})
                  - $signed(LW'(rdlm_pkg::LOG_OFFSET_Q16));
    assign db_mag = prod_reg[PW-1:32];

    assign meter_t    = $signed({db_reg[DB_W-1], db_reg}) + $signed((DB_W+1)'(rdlm_pkg::DB_OFFSET));
    assign meter_n    = {meter_t[5:0], 1'b0};
    assign meter_p    = {8'b0, meter_n} * {7'b0, rdlm_pkg::DIV3_MUL};
    assign meter_next = (meter_t <= 0) ? '0
                      : meter_p[rdlm_pkg::DIV3_SHIFT +: MT_W];

    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_meter_reg, out_db_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg == B_FINISH) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        cnt_reg <= q_cnt;
                        if (q_sum == '0) begin
                            db_reg    <= rdlm_pkg::DB_SILENCE;
                            state_reg <= B_FINISH;
                        end else begin
                            state_reg <= B_LOG_SUM;
                        end
                    end
                end
                B_LOG_SUM: begin
                    if (lg_done) begin
                        lsum_reg  <= lg_result;
                        state_reg <= B_LOG_CNT;
                    end
                end
                B_LOG_CNT: begin
                    if (lg_done) begin
                        if (l_val >= 0) begin
                            db_reg    <= '0;
                            state_reg <= B_FINISH;
                        end else begin
                            mag_reg   <= LW'(-l_val);
                            state_reg <= B_MUL;
                        end
                    end
                end
                B_MUL: begin
                    prod_reg  <= PW'(mag_reg) * PW'(rdlm_pkg::TEN_LOG10_2_Q16);
                    state_reg <= B_SAT;
                end
                B_SAT: begin
                    if (db_mag >= DBM_W'(rdlm_pkg::DB_CLAMP)) begin
                        db_reg <= rdlm_pkg::DB_MIN;
                    end else begin
                        db_reg <= DB_W'(0) - DB_W'(db_mag);
                    end
                    state_reg <= B_FINISH;
                end
                B_FINISH: begin
                    if (out_free) begin
                        out_db_reg    <= db_reg;
                        out_meter_reg <= meter_next;
                        state_reg     <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/rdlm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdlm_checker
// Port-level checks on the level meter's result stream.
// ----------------------------------------------------------------------------
module rdlm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rdlm_pkg::M_TDATA_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_db_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7] || m_tdata[7:0] == 8'd0))
        else $error("dB level above full scale");

    a_meter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:8] <= 6'd40 && m_tdata[15:14] == 2'b00))
        else $error("meter level out of range");

    a_meter_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] && m_tdata[6:0] <= 7'd68 |-> m_tdata[13:8] == 6'd0)
        else $error("meter lit below -60 dBFS");

endmodule

bind rms_dbfs_level_meter rdlm_checker u_rdlm_checker (.*);

/* dv/rms_dbfs_level_meter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_dbfs_level_meter_tb
// Self-checking bench for the chunk level meter: PCM samples in, one dBFS and
// VU level transfer out per closed chunk. A directed table covers silence,
// full scale, the quietest levels and a chunk closed by the sample limit;
// random chunks of random loudness follow. Checks use typed rows or an
// in-bench fixed-point level predictor, with random stalls on both sides, a
// long result hold-off that backs up the intake, and a full drain pause.
// ----------------------------------------------------------------------------
module rms_dbfs_level_meter_tb;

    localparam int          CHUNK_MAX    = rdlm_pkg::MAX_SAMPLES_DEF;
    localparam int          METER_FULL   = 40;
    localparam int          RANDOM_ITEMS = 1000;
    localparam int          HOLD_CYCLES  = 1500;
    localparam int          BURST_CHUNKS = 30;
    localparam int          DRAIN_CYCLES = 300;
    localparam int          ROW_COUNT    = 15;
    localparam longint      TIMEOUT_NS   = 64'd40_000_000;

    typedef struct packed {
        logic signed [rdlm_pkg::DB_W-1:0] db;
        logic [rdlm_pkg::METER_W-1:0]     meter;
    } level_t;

    typedef struct packed {
        logic signed [rdlm_pkg::SAMPLE_W-1:0] sample;
        logic                                 last;
        logic [12:0]                          reps;
        logic                                 typed;
        logic signed [rdlm_pkg::DB_W-1:0]     db;
        logic [rdlm_pkg::METER_W-1:0]         meter;
    } stim_row_t;

    // sample, last, repeat count, typed expectation, db, meter
    localparam stim_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        '{16'sh0000, 1'b1, 13'd1,    1'b1, rdlm_pkg::DB_SILENCE, 6'd0},
        '{16'sh8000, 1'b1, 13'd1,    1'b1, 8'sd0,      6'd40},
        '{16'sh7FFF, 1'b1, 13'd1,    1'b0, 8'sd0,      6'd0},
        '{16'sh0001, 1'b1, 13'd1,    1'b1, -8'sd90,    6'd0},
        '{16'shFFFF, 1'b1, 13'd1,    1'b1, -8'sd90,    6'd0},
        '{16'sh0000, 1'b0, 13'd3,    1'b0, 8'sd0,      6'd0},
        '{16'sh0000, 1'b1, 13'd1,    1'b1, rdlm_pkg::DB_SILENCE, 6'd0},
        '{16'sh5555, 1'b0, 13'd1,    1'b0, 8'sd0,      6'd0},
        '{16'shAAAA, 1'b1, 13'd1,    1'b0, 8'sd0,      6'd0},
        '{16'sh8000, 1'b1, 13'd4,    1'b1, 8'sd0,      6'd40},
        '{16'sh0000, 1'b0, 13'd4095, 1'b0, 8'sd0,      6'd0},
        '{16'sh0001, 1'b0, 13'd1,    1'b1, -8'sd126,   6'd0},
        '{16'sh3039, 1'b1, 13'd1,    1'b0, 8'sd0,      6'd0},
        '{16'sh00FF, 1'b0, 13'd2,    1'b0, 8'sd0,      6'd0},
        '{16'shFF00, 1'b1, 13'd1,    1'b0, 8'sd0,      6'd0}
    };

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rdlm_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tlast  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rdlm_pkg::M_TDATA_W-1:0] m_tdata;

    level_t      pending_levels[$];
    logic [63:0] acc_sum   = '0;
    logic [31:0] acc_count = '0;
    int          error_count  = 0;
    bit          no_idle      = 1'b0;
    bit          hold_request = 1'b0;

    rms_dbfs_level_meter #(
        .MAX_SAMPLES(CHUNK_MAX)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function automatic logic [31:0] log2_fixed(input logic [63:0] x);
        int unsigned msb;
        logic [63:0] mant;
        logic [15:0] frac;
        msb  = 0;
        frac = '0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) msb = i;
        end
        if (msb <= 31) mant = x << (31 - msb);
        else mant = x >> (msb - 31);
        for (int i = 0; i < rdlm_pkg::FRAC_W; i++) begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                mant    = mant >> 1;
            end
        end
        return {msb[15:0], frac};
    endfunction

    function automatic level_t chunk_level(input logic [63:0] sum, input logic [31:0] count);
        longint      ratio_log;
        longint      db_val;
        logic [63:0] mag;
        int          meter_val;
        level_t      lvl;
        if (sum == 0) begin
            db_val = rdlm_pkg::DB_SILENCE;
        end else begin
            if (count == 0) count = 1;
            ratio_log = longint'(log2_fixed(sum)) - longint'(log2_fixed(count))
                        - longint'(rdlm_pkg::LOG_OFFSET_Q16);
            if (ratio_log >= 0) begin
                db_val = 0;
            end else begin
                mag    = 64'(-ratio_log);
                db_val = -longint'((mag * 64'(rdlm_pkg::TEN_LOG10_2_Q16)) >> 32);
                if (db_val < longint'(rdlm_pkg::DB_MIN)) db_val = rdlm_pkg::DB_MIN;
            end
        end
        meter_val = (int'(db_val) + rdlm_pkg::DB_OFFSET) * METER_FULL / rdlm_pkg::DB_OFFSET;
        if (meter_val < 0) meter_val = 0;
        if (meter_val > METER_FULL) meter_val = METER_FULL;
        lvl.db    = db_val[rdlm_pkg::DB_W-1:0];
        lvl.meter = meter_val[rdlm_pkg::METER_W-1:0];
        return lvl;
    endfunction

    function automatic bit absorb_sample(input logic signed [rdlm_pkg::SAMPLE_W-1:0] sample,
                                         input bit last, output level_t lvl);
        int     value;
        longint mag;
        value     = sample;
        mag       = (value < 0) ? -value : value;
        acc_sum   = acc_sum + 64'(mag * mag);
        acc_count = acc_count + 1;
        lvl       = '0;
        if (!last && acc_count < CHUNK_MAX) return 1'b0;
        lvl       = chunk_level(acc_sum, acc_count);
        acc_sum   = '0;
        acc_count = '0;
        return 1'b1;
    endfunction

    task automatic send_sample(input logic signed [rdlm_pkg::SAMPLE_W-1:0] sample,
                               input bit last, input bit typed, input level_t typed_lvl);
        int     gap;
        level_t lvl;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (absorb_sample(sample, last, lvl)) pending_levels.push_back(typed ? typed_lvl : lvl);
    endtask

    task automatic drain_levels();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_levels.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [rdlm_pkg::SAMPLE_W-1:0] random_sample(
        input int unsigned shift);
        unique case ($urandom_range(0, 15))
            0: return 16'sh0000;
            1: return 16'sh8000;
            2: return 16'sh7FFF;
            default: return $signed(16'($urandom)) >>> shift;
        endcase
    endfunction

    // result side: random stalls, long hold-off on request, field checks
    initial begin
        int     stall_left;
        level_t got;
        level_t want;
        stall_left = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.db    = m_tdata[7:0];
                got.meter = m_tdata[13:8];
                if (pending_levels.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer: db %0d meter %0d",
                                              got.db, got.meter));
                end else begin
                    want = pending_levels.pop_front();
                    if (got.db !== want.db)
                        report_mismatch($sformatf("db_level got %0d want %0d",
                                                  got.db, want.db));
                    if (got.meter !== want.meter)
                        report_mismatch($sformatf("meter_level got %0d want %0d",
                                                  got.meter, want.meter));
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (hold_request) begin
                stall_left   = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        stim_row_t   row;
        level_t      row_lvl;
        int          small_items;
        int          chunk_len;
        int unsigned shift;
        bit          last;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_ROWS[r]) begin
            row           = DIRECTED_ROWS[r];
            row_lvl.db    = row.db;
            row_lvl.meter = row.meter;
            for (int k = 0; k < row.reps; k++) begin
                last = (k == row.reps - 1) && row.last;
                send_sample(row.sample, last, row.typed && (k == row.reps - 1), row_lvl);
            end
        end
        drain_levels();

        // hold results off while single-sample chunks back up the intake
        no_idle      = 1'b1;
        hold_request = 1'b1;
        for (int c = 0; c < BURST_CHUNKS; c++) begin
            send_sample(random_sample($urandom_range(0, 15)), 1'b1, 1'b0, '0);
        end
        drain_levels();

        small_items = 0;
        while (small_items < RANDOM_ITEMS) begin
            no_idle     = ($urandom_range(0, 7) == 0);
            shift       = $urandom_range(0, 15);
            chunk_len   = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 24);
            small_items += chunk_len;
            for (int k = 0; k < chunk_len; k++) begin
                last = (k == chunk_len - 1);
                send_sample(random_sample(shift), last, 1'b0, '0);
            end
        end

        drain_levels();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
